/* hdl/record_sort_by_name_defines.svh */
// Assertion macros for the record sorter.
// Used by the top level; no other dependencies.
`ifndef RECORD_SORT_BY_NAME_DEFINES_SVH
`define RECORD_SORT_BY_NAME_DEFINES_SVH

`ifndef SYNTHESIS
`define RSBN_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("record_sort_by_name: assertion failed");
`define RSBN_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("record_sort_by_name: assertion failed");
`else
`define RSBN_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define RSBN_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* hdl/rsbn_pkg.sv */
// Shared constants, record types and the name key function of the record sorter.
// No dependencies.
package rsbn_pkg;

   localparam int MaxRecords = 16;
   localparam int IdxW       = $clog2(MaxRecords);
   localparam int CntW       = $clog2(MaxRecords + 1);
   localparam int NameBytes  = 50;
   localparam int NameW      = NameBytes * 8;

   typedef struct packed {
      logic signed [31:0] id;
      logic [NameW-1:0]   name;
      logic [31:0]        height;
      logic signed [31:0] grade;
   } rec_type;

   typedef struct packed {
      rec_type          rec;
      logic [NameW-1:0] key;
   } entry_type;

   // Zero every byte that follows the first zero byte of the name.
   function automatic logic [NameW-1:0] name_key(input logic [NameW-1:0] name);
      logic [NameBytes-1:0] zero_flags;
      logic [NameBytes-1:0] below;
      logic [NameW-1:0]     key;
      for (int k = 0; k < NameBytes; k++) begin
         zero_flags[k] = (name[NameW-1-8*k -: 8] == 8'h00);
      end
      for (int k = 0; k < NameBytes; k++) begin
         below = (NameBytes'(1) << k) - NameBytes'(1);
         key[NameW-1-8*k -: 8] = (|(zero_flags & below)) ? 8'h00 : name[NameW-1-8*k -: 8];
      end
      return key;
   endfunction

endpackage

/* hdl/rsbn_out.sv */
// Result output register of the record sorter: holds one beat while the receiver stalls.
// Depends on rsbn_pkg.
module rsbn_out (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  rsbn_pkg::rec_type       load_rec,
   input  logic                    load_last,
   output logic                    load_ok,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [31:0]      rsp_out_student_id,
   output logic [63:0]             rsp_out_name_word_0,
   output logic [63:0]             rsp_out_name_word_1,
   output logic [63:0]             rsp_out_name_word_2,
   output logic [63:0]             rsp_out_name_word_3,
   output logic [63:0]             rsp_out_name_word_4,
   output logic [63:0]             rsp_out_name_word_5,
   output logic [15:0]             rsp_out_name_word_6,
   output logic [31:0]             rsp_out_height_bits,
   output logic signed [31:0]      rsp_out_grade,
   output logic                    rsp_out_last
);

   logic              valid_ff;
   rsbn_pkg::rec_type rec_ff;
   logic              last_ff;

   assign load_ok = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rec_ff  <= load_rec;
         last_ff <= load_last;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_out_student_id  = rec_ff.id;
   assign rsp_out_name_word_0 = rec_ff.name[399:336];
   assign rsp_out_name_word_1 = rec_ff.name[335:272];
   assign rsp_out_name_word_2 = rec_ff.name[271:208];
   assign rsp_out_name_word_3 = rec_ff.name[207:144];
   assign rsp_out_name_word_4 = rec_ff.name[143:80];
   assign rsp_out_name_word_5 = rec_ff.name[79:16];
   assign rsp_out_name_word_6 = rec_ff.name[15:0];
   assign rsp_out_height_bits = rec_ff.height;
   assign rsp_out_grade       = rec_ff.grade;
   assign rsp_out_last        = last_ff;

endmodule

/* hdl/record_sort_by_name.sv */
// Record sorter top level: record store, exchange sort sequencer and output control.
// Depends on rsbn_pkg, rsbn_out and record_sort_by_name_defines.svh.
//
// Usage: send student records on the req_ channel, one beat per record, each taking
// one cycle. Up to 16 records are stored; further records are dropped. A beat with
// req_last_record set is stored like any other and then starts the sort; req_stall
// stays high until the last sorted record has been loaded into the output register.
// The sort does one name compare per cycle, paced by the single read port of the
// record store. Records then leave on the rsp_ channel at one beat per cycle while
// rsp_stall is low, in ascending name order, rsp_out_last on the final one.
// A stall on rsp_ holds the current beat and pauses the read-out; the next set
// may start loading while the final beat still waits to be taken.
// Reset (synchronous, active high) empties the store count and the output
// register; store contents are not cleared and need no clearing pass.
`include "record_sort_by_name_defines.svh"
module record_sort_by_name (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_student_id,
   input  logic [63:0]        req_name_word_0,
   input  logic [63:0]        req_name_word_1,
   input  logic [63:0]        req_name_word_2,
   input  logic [63:0]        req_name_word_3,
   input  logic [63:0]        req_name_word_4,
   input  logic [63:0]        req_name_word_5,
   input  logic [15:0]        req_name_word_6,
   input  logic [31:0]        req_height_bits,
   input  logic signed [31:0] req_grade,
   input  logic               req_last_record,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_out_student_id,
   output logic [63:0]        rsp_out_name_word_0,
   output logic [63:0]        rsp_out_name_word_1,
   output logic [63:0]        rsp_out_name_word_2,
   output logic [63:0]        rsp_out_name_word_3,
   output logic [63:0]        rsp_out_name_word_4,
   output logic [63:0]        rsp_out_name_word_5,
   output logic [15:0]        rsp_out_name_word_6,
   output logic [31:0]        rsp_out_height_bits,
   output logic signed [31:0] rsp_out_grade,
   output logic               rsp_out_last
);

   localparam int IdxW = rsbn_pkg::IdxW;
   localparam int CntW = rsbn_pkg::CntW;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RDI   = 3'd1;
   localparam logic [2:0] S_LDI   = 3'd2;
   localparam logic [2:0] S_CMP   = 3'd3;
   localparam logic [2:0] S_WRI   = 3'd4;
   localparam logic [2:0] S_ERD   = 3'd5;
   localparam logic [2:0] S_EWAIT = 3'd6;

   logic [2:0]      state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] n_ff, n_in;
   logic [IdxW-1:0] i_ff, i_in;
   logic [IdxW-1:0] j_ff, j_in;
   logic [IdxW-1:0] e_ff, e_in;

   rsbn_pkg::entry_type store_mem [rsbn_pkg::MaxRecords];
   rsbn_pkg::entry_type rd_data_ff;
   rsbn_pkg::entry_type held_ff, held_in;
   rsbn_pkg::entry_type new_entry;
   rsbn_pkg::entry_type wr_data;
   logic [IdxW-1:0]     rd_addr;
   logic [IdxW-1:0]     wr_addr;
   logic                wr_en;

   logic            req_fire;
   logic            gt;
   logic            out_load;
   logic            out_last;
   logic            out_ok;
   logic [CntW-1:0] n_load;

   assign req_fire = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign gt = (held_ff.key > rd_data_ff.key);
   assign out_last = ((CntW'(e_ff) + CntW'(1)) == n_ff);
   assign n_load = (count_ff < CntW'(rsbn_pkg::MaxRecords)) ? count_ff + CntW'(1) : count_ff;

   always_comb begin
      new_entry.rec.id     = req_student_id;
      new_entry.rec.name   = {req_name_word_0, req_name_word_1, req_name_word_2,
                              req_name_word_3, req_name_word_4, req_name_word_5,
                              req_name_word_6};
      new_entry.rec.height = req_height_bits;
      new_entry.rec.grade  = req_grade;
      new_entry.key        = rsbn_pkg::name_key(new_entry.rec.name);
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      n_in     = n_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      e_in     = e_ff;
      held_in  = held_ff;
      rd_addr  = e_ff;
      wr_en    = 1'b0;
      wr_addr  = i_ff;
      wr_data  = held_ff;
      out_load = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (count_ff < CntW'(rsbn_pkg::MaxRecords)) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[IdxW-1:0];
                  wr_data  = new_entry;
                  count_in = count_ff + CntW'(1);
               end
               if (req_last_record) begin
                  n_in     = n_load;
                  count_in = '0;
                  i_in     = '0;
                  e_in     = '0;
                  state_in = (n_load == CntW'(1)) ? S_ERD : S_RDI;
               end
            end
         end
         S_RDI: begin
            rd_addr  = i_ff;
            state_in = S_LDI;
         end
         S_LDI: begin
            held_in  = rd_data_ff;
            j_in     = i_ff + IdxW'(1);
            rd_addr  = i_ff + IdxW'(1);
            state_in = S_CMP;
         end
         S_CMP: begin
            // swap the held record with the one read at j
            if (gt) begin
               wr_en   = 1'b1;
               wr_addr = j_ff;
               wr_data = held_ff;
               held_in = rd_data_ff;
            end
            if ((CntW'(j_ff) + CntW'(1)) < n_ff) begin
               j_in    = j_ff + IdxW'(1);
               rd_addr = j_ff + IdxW'(1);
            end else begin
               state_in = S_WRI;
            end
         end
         S_WRI: begin
            wr_en   = 1'b1;
            wr_addr = i_ff;
            wr_data = held_ff;
            if ((CntW'(i_ff) + CntW'(2)) < n_ff) begin
               i_in     = i_ff + IdxW'(1);
               rd_addr  = i_ff + IdxW'(1);
               state_in = S_LDI;
            end else begin
               e_in     = '0;
               state_in = S_ERD;
            end
         end
         S_ERD: begin
            rd_addr  = e_ff;
            state_in = S_EWAIT;
         end
         S_EWAIT: begin
            if (out_ok) begin
               out_load = 1'b1;
               if (out_last) begin
                  state_in = S_IDLE;
               end else begin
                  e_in    = e_ff + IdxW'(1);
                  rd_addr = e_ff + IdxW'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      e_ff    <= e_in;
      held_ff <= held_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   rsbn_out u_out (
      .clock               (clock),
      .reset               (reset),
      .load                (out_load),
      .load_rec            (rd_data_ff.rec),
      .load_last           (out_last),
      .load_ok             (out_ok),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_student_id  (rsp_out_student_id),
      .rsp_out_name_word_0 (rsp_out_name_word_0),
      .rsp_out_name_word_1 (rsp_out_name_word_1),
      .rsp_out_name_word_2 (rsp_out_name_word_2),
      .rsp_out_name_word_3 (rsp_out_name_word_3),
      .rsp_out_name_word_4 (rsp_out_name_word_4),
      .rsp_out_name_word_5 (rsp_out_name_word_5),
      .rsp_out_name_word_6 (rsp_out_name_word_6),
      .rsp_out_height_bits (rsp_out_height_bits),
      .rsp_out_grade       (rsp_out_grade),
      .rsp_out_last        (rsp_out_last)
   );

   `RSBN_ASSERT_IMP(a_count_cap, clock, reset, 1'b1, count_ff <= CntW'(rsbn_pkg::MaxRecords))
   `RSBN_ASSERT_IMP(a_cmp_range, clock, reset, state_ff == S_CMP, (j_ff > i_ff) && (CntW'(j_ff) < n_ff))
   `RSBN_ASSERT_IMP(a_sort_wr_range, clock, reset, wr_en && (state_ff != S_IDLE), CntW'(wr_addr) < n_ff)
   `RSBN_ASSERT_NXT(a_last_to_idle, clock, reset, out_load && out_last, (state_ff == S_IDLE) && (count_ff == '0))

endmodule

/* dv/record_sort_by_name_tb.sv */
// Self-checking testbench for record_sort_by_name: loads record sets, predicts the
// exchange-sorted output by name and checks every sorted beat field by field.
// Depends on rsbn_pkg and the record_sort_by_name RTL.
module testbench;

   localparam int MaxRecords = rsbn_pkg::MaxRecords;
   localparam int NameBytes  = rsbn_pkg::NameBytes;
   localparam int NameW      = rsbn_pkg::NameW;

   localparam int CalmTail   = 60;
   localparam int HoldCycles = 400;
   localparam int DrainWait  = 300;
   localparam int IdleLimit  = 4000;
   localparam int RandItems  = 350;

   typedef struct {
      rsbn_pkg::rec_type rec;
      logic              last;
      bit                wait_drain;
   } student_beat_type;

   typedef enum {NAME_SHORT, NAME_RANDOM, NAME_LONG, NAME_TWIN} name_style_type;

   logic clock;
   logic reset     = 1'b1;
   logic req_valid = 1'b0;
   logic rsp_stall = 1'b0;
   logic req_stall;
   logic rsp_valid;
   logic signed [31:0] rsp_out_student_id;
   logic [63:0] rsp_out_name_word_0, rsp_out_name_word_1, rsp_out_name_word_2;
   logic [63:0] rsp_out_name_word_3, rsp_out_name_word_4, rsp_out_name_word_5;
   logic [15:0] rsp_out_name_word_6;
   logic [31:0] rsp_out_height_bits;
   logic signed [31:0] rsp_out_grade;
   logic rsp_out_last;

   student_beat_type drv_beat = '{rec: '0, last: 1'b0, wait_drain: 1'b0};
   student_beat_type pending[$];
   student_beat_type sorted_due[$];

   rsbn_pkg::rec_type roster[MaxRecords];
   int roster_count = 0;

   int records_queued = 0;
   int records_in     = 0;
   int sets_in        = 0;
   int beats_out      = 0;
   int mismatches     = 0;
   int send_gap       = 0;
   int send_gap_pct   = 0;
   int stall_left     = 0;
   int stall_pct      = 0;
   int hold_left      = 0;
   bit hold_done      = 1'b0;
   int idle_cycles    = 0;

   record_sort_by_name uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_student_id      (drv_beat.rec.id),
      .req_name_word_0     (drv_beat.rec.name[NameW-1   -: 64]),
      .req_name_word_1     (drv_beat.rec.name[NameW-65  -: 64]),
      .req_name_word_2     (drv_beat.rec.name[NameW-129 -: 64]),
      .req_name_word_3     (drv_beat.rec.name[NameW-193 -: 64]),
      .req_name_word_4     (drv_beat.rec.name[NameW-257 -: 64]),
      .req_name_word_5     (drv_beat.rec.name[NameW-321 -: 64]),
      .req_name_word_6     (drv_beat.rec.name[15:0]),
      .req_height_bits     (drv_beat.rec.height),
      .req_grade           (drv_beat.rec.grade),
      .req_last_record     (drv_beat.last),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_student_id  (rsp_out_student_id),
      .rsp_out_name_word_0 (rsp_out_name_word_0),
      .rsp_out_name_word_1 (rsp_out_name_word_1),
      .rsp_out_name_word_2 (rsp_out_name_word_2),
      .rsp_out_name_word_3 (rsp_out_name_word_3),
      .rsp_out_name_word_4 (rsp_out_name_word_4),
      .rsp_out_name_word_5 (rsp_out_name_word_5),
      .rsp_out_name_word_6 (rsp_out_name_word_6),
      .rsp_out_height_bits (rsp_out_height_bits),
      .rsp_out_grade       (rsp_out_grade),
      .rsp_out_last        (rsp_out_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic bit name_after(logic [NameW-1:0] a, logic [NameW-1:0] b);
      logic [7:0] x, y;
      for (int k = 0; k < NameBytes; k++) begin
         x = a[NameW-1-8*k -: 8];
         y = b[NameW-1-8*k -: 8];
         if (x != y) return x > y;
         if (x == 8'h00) return 1'b0;
      end
      return 1'b0;
   endfunction

   // Store the beat, and on the closing beat of a set sort the roster and queue it.
   function automatic void file_and_sort(student_beat_type b);
      rsbn_pkg::rec_type tmp;
      student_beat_type outb;
      if (roster_count < MaxRecords) begin
         roster[roster_count] = b.rec;
         roster_count++;
      end
      if (!b.last) return;
      for (int i = 0; i < roster_count; i++) begin
         for (int j = i + 1; j < roster_count; j++) begin
            if (name_after(roster[i].name, roster[j].name)) begin
               tmp       = roster[i];
               roster[i] = roster[j];
               roster[j] = tmp;
            end
         end
      end
      for (int i = 0; i < roster_count; i++) begin
         outb.rec        = roster[i];
         outb.last       = (i == roster_count - 1);
         outb.wait_drain = 1'b0;
         sorted_due.push_back(outb);
      end
      roster_count = 0;
   endfunction

   function automatic int pick_pct();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 20;
         default: return 50;
      endcase
   endfunction

   function automatic logic [NameW-1:0] text_name(string s);
      logic [NameW-1:0] nm;
      nm = '0;
      for (int k = 0; k < s.len() && k < NameBytes; k++) begin
         nm[NameW-1-8*k -: 8] = s[k];
      end
      return nm;
   endfunction

   function automatic logic [NameW-1:0] make_name(name_style_type style, logic [NameW-1:0] twin);
      logic [NameW-1:0] nm;
      int len;
      int z;
      bit junk;
      nm   = '0;
      z    = NameBytes;
      junk = $urandom_range(0, 1);
      case (style)
         NAME_RANDOM: begin
            for (int k = 0; k < NameBytes; k++) nm[NameW-1-8*k -: 8] = 8'($urandom_range(0, 255));
         end
         NAME_SHORT: begin
            len = $urandom_range(0, 5);
            for (int k = 0; k < len; k++) nm[NameW-1-8*k -: 8] = 8'("A" + $urandom_range(0, 2));
            z = len;
         end
         NAME_LONG: begin
            len = $urandom_range(46, NameBytes);
            for (int k = 0; k < len; k++) begin
               nm[NameW-1-8*k -: 8] = ($urandom_range(0, 7) == 0) ? "B" : "A";
            end
            z = len;
         end
         default: begin
            nm = twin;
            for (int k = NameBytes - 1; k >= 0; k--) begin
               if (nm[NameW-1-8*k -: 8] == 8'h00) z = k;
            end
         end
      endcase
      if (junk) begin
         for (int k = z + 1; k < NameBytes; k++) nm[NameW-1-8*k -: 8] = 8'($urandom_range(0, 255));
      end
      return nm;
   endfunction

   task automatic queue_record(logic signed [31:0] id, logic [NameW-1:0] nm, logic [31:0] ht,
                               logic signed [31:0] gr, logic last, bit drain);
      student_beat_type b;
      b.rec.id     = id;
      b.rec.name   = nm;
      b.rec.height = ht;
      b.rec.grade  = gr;
      b.last       = last;
      b.wait_drain = drain;
      pending.push_back(b);
      records_queued++;
   endtask

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      mismatches++;
      if (mismatches <= 40) begin
         $display("tb: mismatch on %s at sorted beat %0d: got %h, expected %h",
                  field, beats_out, got, want);
      end
   endtask

   always @(posedge clock) begin
      bit send;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            file_and_sort(drv_beat);
            records_in++;
            if (drv_beat.last) begin
               sets_in++;
               send_gap_pct = pick_pct();
            end
         end
         if (!req_valid || !req_stall) begin
            send = 1'b0;
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending.size() != 0 &&
                         !(pending[0].wait_drain && sorted_due.size() != 0)) begin
               if (pending.size() >= CalmTail && $urandom_range(0, 99) < send_gap_pct) begin
                  send_gap = $urandom_range(0, 16);
               end else begin
                  send = 1'b1;
               end
            end
            if (send) drv_beat <= pending.pop_front();
            req_valid <= send;
         end
      end
   end

   always @(posedge clock) begin
      student_beat_type want;
      logic [NameW-1:0] got_name;
      bit stall;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (sorted_due.size() == 0) begin
               report_mismatch("unexpected beat", 64'(rsp_out_student_id), '0);
            end else begin
               want = sorted_due.pop_front();
               got_name = {rsp_out_name_word_0, rsp_out_name_word_1, rsp_out_name_word_2,
                           rsp_out_name_word_3, rsp_out_name_word_4, rsp_out_name_word_5,
                           rsp_out_name_word_6};
               if (rsp_out_student_id !== want.rec.id)
                  report_mismatch("student_id", 64'(rsp_out_student_id), 64'(want.rec.id));
               for (int w = 0; w < 6; w++) begin
                  if (got_name[NameW-1-64*w -: 64] !== want.rec.name[NameW-1-64*w -: 64])
                     report_mismatch($sformatf("name_word_%0d", w), got_name[NameW-1-64*w -: 64],
                                     want.rec.name[NameW-1-64*w -: 64]);
               end
               if (got_name[15:0] !== want.rec.name[15:0])
                  report_mismatch("name_word_6", 64'(got_name[15:0]), 64'(want.rec.name[15:0]));
               if (rsp_out_height_bits !== want.rec.height)
                  report_mismatch("height_bits", 64'(rsp_out_height_bits), 64'(want.rec.height));
               if (rsp_out_grade !== want.rec.grade)
                  report_mismatch("grade", 64'(rsp_out_grade), 64'(want.rec.grade));
               if (rsp_out_last !== want.last)
                  report_mismatch("last", 64'(rsp_out_last), 64'(want.last));
            end
            beats_out++;
            if (rsp_out_last) stall_pct = pick_pct();
         end
         stall = 1'b0;
         if (hold_left > 0) begin
            hold_left--;
            stall = 1'b1;
         end else if (!hold_done && beats_out >= 30) begin
            hold_done = 1'b1;
            hold_left = HoldCycles - 1;
            stall     = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            stall = 1'b1;
         end else if (pending.size() >= CalmTail && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 16);
            stall      = 1'b1;
         end
         rsp_stall <= stall;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      logic [NameW-1:0] set_names[20];
      logic [NameW-1:0] nm;
      int rand_items;
      int n;
      int pick;
      bit drain;

      // lone record with extreme fields and an unterminated name
      queue_record(32'sh8000_0000, {NameW{1'b1}}, 32'h0000_0000, 32'sh7fff_ffff, 1'b1, 1'b0);

      // empty name, equal keys with trailing bytes, identical unterminated names
      nm = text_name("A");
      nm[NameW-1-8*2 -: 8] = 8'h5a;
      queue_record(32'sh7fff_ffff, '0, 32'hffff_ffff, 32'sh8000_0000, 1'b0, 1'b1);
      queue_record(32'sd1, text_name("B"), 32'h3f80_0000, -32'sd1, 1'b0, 1'b0);
      queue_record(32'sd2, nm, 32'h4000_0000, 32'sd0, 1'b0, 1'b0);
      queue_record(32'sd3, text_name("A"), 32'h4040_0000, 32'sd5, 1'b0, 1'b0);
      queue_record(32'sd4, {NameW{1'b1}}, 32'h8000_0000, 32'sd6, 1'b0, 1'b0);
      queue_record(32'sd5, {NameW{1'b1}}, 32'h7f80_0000, 32'sd7, 1'b0, 1'b0);
      queue_record(32'sd6, text_name({49{"A"}}), 32'h1234_5678, 32'sd8, 1'b0, 1'b0);
      queue_record(32'sd7, text_name({50{"A"}}), 32'h8765_4321, 32'sd9, 1'b1, 1'b0);

      // full store: the closing beat is dropped but still starts the sort
      for (int r = 0; r <= MaxRecords; r++) begin
         queue_record($urandom, make_name(NAME_SHORT, '0), $urandom, $urandom,
                      r == MaxRecords, 1'b0);
      end

      rand_items = 0;
      while (rand_items < RandItems) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) n = $urandom_range(1, 8);
         else if (pick < 9) n = $urandom_range(9, MaxRecords);
         else n = $urandom_range(MaxRecords + 1, 20);
         drain = (rand_items == 0) || ($urandom_range(0, 19) == 0);
         for (int r = 0; r < n; r++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4 || (pick >= 7 && r == 0)) nm = make_name(NAME_SHORT, '0);
            else if (pick == 4) nm = make_name(NAME_RANDOM, '0);
            else if (pick < 7) nm = make_name(NAME_LONG, '0);
            else nm = make_name(NAME_TWIN, set_names[$urandom_range(0, r - 1)]);
            set_names[r] = nm;
            queue_record($urandom, nm, $urandom, $urandom, r == n - 1, drain && r == 0);
         end
         rand_items += n;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (records_in < records_queued) @(posedge clock);
      while (sorted_due.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);

      $display("tb: %0d records in %0d sets loaded, %0d sorted records compared",
               records_in, sets_in, beats_out);
      $display("tb: covered empty, equal and unterminated names, overfull sets, long stalls");
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+hdl
hdl/rsbn_pkg.sv
hdl/rsbn_out.sv
hdl/record_sort_by_name.sv
dv/record_sort_by_name_tb.sv
